[hw/rtl/glr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package glr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int JOB_QUEUE_DEPTH = 2;

    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int K_W       = $clog2(CHAN_W);
    localparam int OFFSET_W  = 28;
    localparam int FB_DIM_W  = 12;
    localparam int PITCH_W   = 16;
    localparam int BPP_W     = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FB_WIDTH        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FB_HEIGHT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd3;

    localparam logic [FB_DIM_W-1:0] FB_WIDTH_RST        = 12'd1024;
    localparam logic [FB_DIM_W-1:0] FB_HEIGHT_RST       = 12'd768;
    localparam logic [PITCH_W-1:0]  ROW_PITCH_RST       = 16'd4096;
    localparam logic [BPP_W-1:0]    BYTES_PER_PIXEL_RST = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/glr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module glr_front
    import glr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int JOB_W      = 4 * COORD_BITS + 2 * COLOR_W + 2
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_take,
    input  wire logic                         op,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    input  wire logic [COLOR_W-1:0]           color_start,
    input  wire logic [COLOR_W-1:0]           color_end,
    input  wire logic [FB_DIM_W-1:0]          fb_width,
    input  wire logic [FB_DIM_W-1:0]          fb_height,
    output logic                              job_push,
    output logic [JOB_W-1:0]                  job_data
);

    localparam int C     = COORD_BITS;
    localparam int ERR_W = C + 2;
    localparam int E2_W  = C + 3;
    localparam int VIS_W = C + FB_DIM_W;

    logic                 active_reg;
    logic signed [C-1:0]  cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    logic [C-1:0]         delta_x_reg, delta_y_reg;
    logic                 step_x_neg_reg, step_y_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [C-1:0]         idx_reg, count_reg;
    logic [COLOR_W-1:0]   first_color_reg, last_color_reg;

    logic signed [C:0]    ld_dx_wide, ld_dy_wide;
    logic [C:0]           ld_dx_abs, ld_dy_abs;
    logic [C-1:0]         ld_dx, ld_dy;
    logic signed [ERR_W-1:0] ld_err;

    logic signed [E2_W-1:0] e2, dx_ext, dy_ext, err_next_wide;
    logic                 move_x, move_y, fin, vis;
    logic [C-1:0]         step_x, step_y;

    logic is_load, is_tick;

    assign is_load = in_take && (op == OP_LOAD);
    assign is_tick = in_take && (op == OP_TICK) && active_reg;

    always_comb
    begin
        ld_dx_wide = {x_end[C-1], x_end} - {x_start[C-1], x_start};
        ld_dy_wide = {y_end[C-1], y_end} - {y_start[C-1], y_start};
        ld_dx_abs  = ld_dx_wide[C] ? $unsigned(-ld_dx_wide) : $unsigned(ld_dx_wide);
        ld_dy_abs  = ld_dy_wide[C] ? $unsigned(-ld_dy_wide) : $unsigned(ld_dy_wide);
        ld_dx      = ld_dx_abs[C-1:0];
        ld_dy      = ld_dy_abs[C-1:0];
        ld_err     = $signed({2'b00, ld_dx}) - $signed({2'b00, ld_dy});
    end

    always_comb
    begin
        e2      = $signed({err_reg, 1'b0});
        dx_ext  = $signed({3'b000, delta_x_reg});
        dy_ext  = $signed({3'b000, delta_y_reg});
        move_x  = e2 > -dy_ext;
        move_y  = e2 < dx_ext;
        err_next_wide = $signed({err_reg[ERR_W-1], err_reg})
                        - (move_x ? dy_ext : '0)
                        + (move_y ? dx_ext : '0);
        step_x  = step_x_neg_reg ? {C{1'b1}} : C'(1);
        step_y  = step_y_neg_reg ? {C{1'b1}} : C'(1);
        fin     = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
        vis     = !cur_x_reg[C-1] && !cur_y_reg[C-1]
                  && (VIS_W'($unsigned(cur_x_reg)) < VIS_W'(fb_width))
                  && (VIS_W'($unsigned(cur_y_reg)) < VIS_W'(fb_height));
    end

    assign job_push = is_tick;
    assign job_data = {fin, vis, first_color_reg, last_color_reg, count_reg, idx_reg,
                       cur_y_reg, cur_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (is_load)
        begin
            active_reg <= 1'b1;
        end
        else if (is_tick && fin)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            cur_x_reg       <= x_start;
            cur_y_reg       <= y_start;
            goal_x_reg      <= x_end;
            goal_y_reg      <= y_end;
            delta_x_reg     <= ld_dx;
            delta_y_reg     <= ld_dy;
            step_x_neg_reg  <= !(x_start < x_end);
            step_y_neg_reg  <= !(y_start < y_end);
            err_reg         <= ld_err;
            idx_reg         <= '0;
            count_reg       <= (ld_dx > ld_dy) ? ld_dx : ld_dy;
            first_color_reg <= color_start;
            last_color_reg  <= color_end;
        end
        else if (is_tick && !fin)
        begin
            err_reg <= err_next_wide[ERR_W-1:0];
            if (move_x)
            begin
                cur_x_reg <= cur_x_reg + step_x;
            end
            if (move_y)
            begin
                cur_y_reg <= cur_y_reg + step_y;
            end
            idx_reg <= idx_reg + C'(1);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/glr_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module glr_fifo
    import glr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = JOB_QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/glr_lerp.sv]
`timescale 1ns / 1ps
`default_nettype none

module glr_lerp
    import glr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [CHAN_W-1:0]     chan_first,
    input  wire logic [CHAN_W-1:0]     chan_last,
    input  wire logic [COORD_BITS-1:0] idx,
    input  wire logic [COORD_BITS-1:0] count,
    output logic                       busy,
    output logic                       done,
    output logic [CHAN_W-1:0]          chan_out
);

    localparam int NUM_W = CHAN_W + COORD_BITS;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;

    logic [1:0]            state_reg;
    logic                  done_reg;
    logic [K_W-1:0]        k_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [CHAN_W-1:0]     q_reg, base_reg, diff_reg;
    logic                  down_reg;
    logic [COORD_BITS-1:0] idx_reg, count_reg;

    logic [NUM_W-1:0]      shifted;
    logic                  take;

    // quotient is known to stay below 256 since idx never exceeds count
    assign shifted  = NUM_W'(count_reg) << k_reg;
    assign take     = rem_reg >= shifted;
    assign busy     = (state_reg != L_IDLE);
    assign done     = done_reg;
    assign chan_out = down_reg ? (base_reg - q_reg) : (base_reg + q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_MUL;
                    end
                end
                L_MUL:
                begin
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    if (k_reg == '0)
                    begin
                        state_reg <= L_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == L_IDLE))
        begin
            base_reg  <= chan_first;
            down_reg  <= chan_last < chan_first;
            diff_reg  <= (chan_last < chan_first) ? (chan_first - chan_last)
                                                  : (chan_last - chan_first);
            idx_reg   <= idx;
            count_reg <= count;
            q_reg     <= '0;
        end
        else if (state_reg == L_MUL)
        begin
            rem_reg <= NUM_W'(diff_reg) * NUM_W'(idx_reg);
            k_reg   <= K_W'(CHAN_W - 1);
        end
        else if (state_reg == L_DIV)
        begin
            if (take)
            begin
                rem_reg      <= rem_reg - shifted;
                q_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - K_W'(1);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/glr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module glr_back
    import glr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int JOB_W      = 4 * COORD_BITS + 2 * COLOR_W + 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   job_empty,
    input  wire logic [JOB_W-1:0]       job_data,
    output logic                        job_pop,
    input  wire logic [PITCH_W-1:0]     row_pitch,
    input  wire logic [BPP_W-1:0]       bytes_per_pixel,
    input  wire logic                   pop,
    output logic                        out_valid,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_W-1:0]          pixel_color,
    output logic [OFFSET_W-1:0]         byte_offset,
    output logic                        visible,
    output logic                        last
);

    localparam int C           = COORD_BITS;
    localparam int X_LSB       = 0;
    localparam int Y_LSB       = C;
    localparam int IDX_LSB     = 2 * C;
    localparam int CNT_LSB     = 3 * C;
    localparam int LCOLOR_LSB  = 4 * C;
    localparam int FCOLOR_LSB  = 4 * C + COLOR_W;
    localparam int VIS_BIT     = 4 * C + 2 * COLOR_W;
    localparam int FIN_BIT     = VIS_BIT + 1;
    localparam int ROW_W       = C + PITCH_W;
    localparam int COL_W       = C + BPP_W;
    localparam int SUM_W       = ROW_W + 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_RUN  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]       state_reg;
    logic [JOB_W-1:0] job_reg;
    logic [ROW_W-1:0] row_prod_reg;
    logic [COL_W-1:0] col_prod_reg;
    logic             out_valid_reg;

    logic [2:0]        lerp_busy, lerp_done;
    logic [CHAN_W-1:0] chan_res [3];

    logic [COLOR_W-1:0] head_first, head_last, job_first;
    logic [C-1:0]       head_idx, head_count, job_count;
    logic [SUM_W-1:0]   offset_sum;
    logic               out_load;

    assign head_first = job_data[FCOLOR_LSB +: COLOR_W];
    assign head_last  = job_data[LCOLOR_LSB +: COLOR_W];
    assign head_idx   = job_data[IDX_LSB +: C];
    assign head_count = job_data[CNT_LSB +: C];
    assign job_first  = job_reg[FCOLOR_LSB +: COLOR_W];
    assign job_count  = job_reg[CNT_LSB +: C];

    assign job_pop    = (state_reg == B_IDLE) && !job_empty;
    assign out_load   = (state_reg == B_OUT) && (!out_valid_reg || pop);
    assign out_valid  = out_valid_reg;
    assign offset_sum = SUM_W'(row_prod_reg) + SUM_W'(col_prod_reg);

    // one unit per color channel, red in the high byte
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_chan
        glr_lerp #(
            .COORD_BITS(COORD_BITS)
        ) u_lerp (
            .clk        (clk),
            .rst_n      (rst_n),
            .start      (job_pop),
            .chan_first (head_first[ch*CHAN_W +: CHAN_W]),
            .chan_last  (head_last[ch*CHAN_W +: CHAN_W]),
            .idx        (head_idx),
            .count      (head_count),
            .busy       (lerp_busy[ch]),
            .done       (lerp_done[ch]),
            .chan_out   (chan_res[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (job_pop)
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_RUN;
                end
                B_RUN:
                begin
                    if (lerp_done[0])
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_data;
        end
        if (state_reg == B_MUL)
        begin
            row_prod_reg <= ROW_W'(job_reg[Y_LSB +: C]) * ROW_W'(row_pitch);
            col_prod_reg <= COL_W'(job_reg[X_LSB +: C]) * COL_W'(bytes_per_pixel);
        end
        if (out_load)
        begin
            pixel_x     <= $signed(job_reg[X_LSB +: C]);
            pixel_y     <= $signed(job_reg[Y_LSB +: C]);
            pixel_color <= (job_count == '0) ? job_first
                                             : {chan_res[2], chan_res[1], chan_res[0]};
            byte_offset <= job_reg[VIS_BIT] ? OFFSET_W'(offset_sum) : '0;
            visible     <= job_reg[VIS_BIT];
            last        <= job_reg[FIN_BIT];
        end
    end

    a_lerp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lerp_busy[0] == lerp_busy[1]) && (lerp_busy[1] == lerp_busy[2]))
        else $error("channel units out of step");

    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RUN) |-> (lerp_busy[0] || lerp_done[0]))
        else $error("waiting on an idle channel unit");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !lerp_busy[0])
        else $error("job fetched while channel units busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && !$past(out_load)))
        else $error("result register overwritten before transaction");

endmodule

`default_nettype wire

[hw/rtl/gradient_line_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer with per-channel color interpolation. A load
// transaction (op = 0) sets up a line and returns nothing; each tick
// transaction (op = 1) returns the next pixel with its clip flag, byte
// offset and a last flag on the end point; ticks with no line loaded return
// nothing. The front end steps the line at one tick per cycle into a two-entry
// job queue, while the queue is not full; the back end takes one pixel at a
// time: fetch, a multiply step, eight shift-subtract steps of the per-channel
// dividers that scale the color difference by index / step count, a step to
// see the dividers finish, then the result register once it is free. One
// result waits in the output register while the next one is
// computed. Configuration writes are taken every cycle (ready is always high)
// and must only happen while the block is idle.

module gradient_line_rasterizer
    import glr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         op,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    input  wire logic [COLOR_W-1:0]           color_start,
    input  wire logic [COLOR_W-1:0]           color_end,

    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic [COLOR_W-1:0]                pixel_color,
    output logic [OFFSET_W-1:0]               byte_offset,
    output logic                              visible,
    output logic                              last,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int JOB_W = 4 * COORD_BITS + 2 * COLOR_W + 2;

    logic [FB_DIM_W-1:0] fb_width_reg, fb_height_reg;
    logic [PITCH_W-1:0]  row_pitch_reg;
    logic [BPP_W-1:0]    bpp_reg;

    logic             in_take;
    logic             job_push, job_pop, job_empty;
    logic [JOB_W-1:0] job_wdata, job_rdata;
    logic             out_valid;

    assign cfg_ready = 1'b1;
    assign in_take   = push && !full;
    assign empty     = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= FB_WIDTH_RST;
            fb_height_reg <= FB_HEIGHT_RST;
            row_pitch_reg <= ROW_PITCH_RST;
            bpp_reg       <= BYTES_PER_PIXEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FB_WIDTH:        fb_width_reg  <= cfg_data[FB_DIM_W-1:0];
                REG_FB_HEIGHT:       fb_height_reg <= cfg_data[FB_DIM_W-1:0];
                REG_ROW_PITCH:       row_pitch_reg <= cfg_data[PITCH_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg       <= cfg_data[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    glr_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .op          (op),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .color_start (color_start),
        .color_end   (color_end),
        .fb_width    (fb_width_reg),
        .fb_height   (fb_height_reg),
        .job_push    (job_push),
        .job_data    (job_wdata)
    );

    glr_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (job_push),
        .wdata (job_wdata),
        .rd_en (job_pop),
        .rdata (job_rdata),
        .full  (full),
        .empty (job_empty)
    );

    glr_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_empty       (job_empty),
        .job_data        (job_rdata),
        .job_pop         (job_pop),
        .row_pitch       (row_pitch_reg),
        .bytes_per_pixel (bpp_reg),
        .pop             (pop),
        .out_valid       (out_valid),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .pixel_color     (pixel_color),
        .byte_offset     (byte_offset),
        .visible         (visible),
        .last            (last)
    );

endmodule

`default_nettype wire
